@@ hdl/msd_pkg.sv @@
// Shared types, constants and letter table for the Morse symbol decoder.
package msd_pkg;

	localparam int MAX_CODE_LENGTH = 4;
	localparam int TREE_DEPTH      = 4;
	localparam int CODE_LIMIT      = (MAX_CODE_LENGTH < TREE_DEPTH) ? MAX_CODE_LENGTH : TREE_DEPTH;
	localparam int POS_W           = TREE_DEPTH + 1;

	localparam logic [POS_W-1:0] NODE_ROOT  = POS_W'(1);
	// first node at the depth where the walk may not descend further
	localparam logic [POS_W-1:0] NODE_LIMIT = POS_W'(1) << CODE_LIMIT;

	localparam logic [7:0] SYM_DOT   = 8'h2E;
	localparam logic [7:0] SYM_DASH  = 8'h2D;
	localparam logic [7:0] SYM_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_NONE   = 8'h00;

	localparam logic [1:0] SEP_NONE  = 2'd0;
	localparam logic [1:0] SEP_ONE   = 2'd1;
	localparam logic [1:0] SEP_TWO   = 2'd2;
	localparam logic [1:0] SEP_MAX   = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_LETTER,
		OP_SPACE,
		OP_STOP_SPACE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] node;
		logic             ovf;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] letter_of(input logic [4:0] node);
		logic [7:0] ch;
		unique case (node)
			5'd2:  ch = "E";
			5'd3:  ch = "T";
			5'd4:  ch = "I";
			5'd5:  ch = "A";
			5'd6:  ch = "N";
			5'd7:  ch = "M";
			5'd8:  ch = "S";
			5'd9:  ch = "U";
			5'd10: ch = "R";
			5'd11: ch = "W";
			5'd12: ch = "D";
			5'd13: ch = "K";
			5'd14: ch = "G";
			5'd15: ch = "O";
			5'd16: ch = "H";
			5'd17: ch = "V";
			5'd18: ch = "F";
			5'd20: ch = "L";
			5'd22: ch = "P";
			5'd23: ch = "J";
			5'd24: ch = "B";
			5'd25: ch = "X";
			5'd26: ch = "C";
			5'd27: ch = "Y";
			5'd28: ch = "Z";
			5'd29: ch = "Q";
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

endpackage

@@ hdl/morse_symbol_decoder_unit.sv @@
// Top level of the Morse symbol decoder.
// Takes one ASCII Morse symbol per clock while full is low ('.', '-', '/', anything
// else clears the slash run) and returns decoded characters through a queue-style
// result port. The front end keeps the tree walk and accepts a symbol every cycle
// while its 4-entry command queue has room; the back end turns each command into
// result words through a one-word output register, one word per cycle while the
// result is popped or the register is empty, so a third slash (period then space)
// gives two result words. The first result word passes through the command queue
// and the output register before it is on the ports; full reflects only the queue.
module morse_symbol_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] symbol,
	input  logic       end_of_message,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       retract_previous,
	output logic       invalid_code,
	output logic       last
);

	msd_pkg::cmd_t      cmd, head;
	msd_pkg::q_status_t q_status;
	logic               cmd_push, q_pop;

	assign full = q_status.full;

	msd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (push && !q_status.full),
		.symbol        (symbol),
		.end_of_message(end_of_message),
		.cmd_push      (cmd_push),
		.cmd           (cmd)
	);

	msd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.push_cmd(cmd),
		.pop     (q_pop),
		.head    (head),
		.status  (q_status)
	);

	msd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_status.empty),
		.q_head          (head),
		.q_pop           (q_pop),
		.pop             (pop),
		.empty           (empty),
		.out_char        (out_char),
		.retract_previous(retract_previous),
		.invalid_code    (invalid_code),
		.last            (last)
	);

endmodule

@@ hdl/msd_front.sv @@
// Front end: takes symbols, walks the code tree, emits letter and gap commands.
module msd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            symbol,
	input  logic                  end_of_message,
	output logic                  cmd_push,
	output msd_pkg::cmd_t         cmd
);

	logic [msd_pkg::POS_W-1:0] pos_q, pos_n;
	logic                      ovf_q, ovf_n;
	logic [1:0]                sep_q, sep_n;
	logic                      cmd_valid;

	always_comb begin
		pos_n     = pos_q;
		ovf_n     = ovf_q;
		sep_n     = sep_q;
		cmd_valid = 1'b0;
		cmd       = '{op: msd_pkg::OP_LETTER, node: pos_q, ovf: ovf_q};

		if (symbol == msd_pkg::SYM_SLASH) begin
			if (sep_q != msd_pkg::SEP_MAX) begin
				sep_n     = sep_q + 2'd1;
				cmd_valid = 1'b1;
				unique case (sep_q)
					msd_pkg::SEP_NONE: begin
						pos_n = msd_pkg::NODE_ROOT;
						ovf_n = 1'b0;
					end
					msd_pkg::SEP_ONE: cmd.op = msd_pkg::OP_SPACE;
					msd_pkg::SEP_TWO: cmd.op = msd_pkg::OP_STOP_SPACE;
					default: cmd_valid = 1'b0;
				endcase
			end
		end else begin
			sep_n = msd_pkg::SEP_NONE;
			if (symbol == msd_pkg::SYM_DOT || symbol == msd_pkg::SYM_DASH) begin
				if (ovf_q || pos_q >= msd_pkg::NODE_LIMIT) begin
					ovf_n = 1'b1;
				end else begin
					pos_n = {pos_q[msd_pkg::POS_W-2:0], symbol == msd_pkg::SYM_DASH};
				end
			end
		end

		// flush an unfinished letter; a slash letter never coincides with this
		if (end_of_message && (pos_n != msd_pkg::NODE_ROOT || ovf_n)) begin
			cmd_valid = 1'b1;
			cmd       = '{op: msd_pkg::OP_LETTER, node: pos_n, ovf: ovf_n};
			pos_n     = msd_pkg::NODE_ROOT;
			ovf_n     = 1'b0;
		end
	end

	assign cmd_push = take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= msd_pkg::NODE_ROOT;
			ovf_q <= 1'b0;
			sep_q <= msd_pkg::SEP_NONE;
		end else if (take) begin
			pos_q <= pos_n;
			ovf_q <= ovf_n;
			sep_q <= sep_n;
		end
	end

endmodule

@@ hdl/msd_queue.sv @@
// Short command queue between front and back end.
module msd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  msd_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output msd_pkg::cmd_t      head,
	output msd_pkg::q_status_t status
);

	msd_pkg::cmd_t              entry_q [msd_pkg::QUEUE_DEPTH];
	logic [msd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [msd_pkg::QPTR_W:0]   cnt_q;
	logic                       do_push, do_pop;

	assign status.full  = cnt_q == (msd_pkg::QPTR_W+1)'(msd_pkg::QUEUE_DEPTH);
	assign status.empty = cnt_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ hdl/msd_back.sv @@
// Back end: expands commands into result words and holds the output register.
module msd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  msd_pkg::cmd_t q_head,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic [7:0]    out_char,
	output logic          retract_previous,
	output logic          invalid_code,
	output logic          last
);

	logic       out_valid_q;
	logic       phase_q;
	logic       load;
	logic       first_half;
	logic [7:0] letter;
	logic [7:0] ch_n;
	logic       retract_n, invalid_n, last_n;

	assign load       = (!out_valid_q || pop) && !q_empty;
	// period goes out first, the space on the next word
	assign first_half = (q_head.op == msd_pkg::OP_STOP_SPACE) && !phase_q;
	assign q_pop      = load && !first_half;
	assign empty      = !out_valid_q;
	assign letter     = q_head.ovf ? msd_pkg::CH_NONE : msd_pkg::letter_of(q_head.node);

	always_comb begin
		ch_n      = msd_pkg::CH_SPACE;
		retract_n = 1'b0;
		invalid_n = 1'b0;
		last_n    = 1'b1;
		unique case (q_head.op)
			msd_pkg::OP_LETTER: begin
				ch_n      = letter;
				invalid_n = letter == msd_pkg::CH_NONE;
			end
			msd_pkg::OP_STOP_SPACE: begin
				if (first_half) begin
					ch_n      = msd_pkg::CH_PERIOD;
					retract_n = 1'b1;
					last_n    = 1'b0;
				end
			end
			default: ch_n = msd_pkg::CH_SPACE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= first_half;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char         <= ch_n;
			retract_previous <= retract_n;
			invalid_code     <= invalid_n;
			last             <= last_n;
		end
	end

endmodule
